/* hdl/nsb_pkg.sv */
// ----------------------------------------------------------------------------
// nsb_pkg
// Shared types and constants of the nine-slice border normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package nsb_pkg;

  localparam int FracW = 17;
  localparam logic [16:0] FracOne = 17'd65536;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_MANUAL = 2'd1,
    MODE_AUTO   = 2'd2,
    MODE_RSVD   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_FILL    = 3'd1,
    REG_MULT    = 3'd2,
    REG_SB_L    = 3'd3,
    REG_SB_R    = 3'd4,
    REG_SB_B    = 3'd5,
    REG_SB_T    = 3'd6,
    REG_NONE    = 3'd7
  } reg_idx_t;

  // classified job handed from the front to the back
  typedef struct packed {
    logic        neutral;
    logic        auto_mode;
    logic        fill;
    logic [23:0] lw;
    logic [23:0] lh;
    logic [15:0] tw;
    logic [15:0] th;
    logic [23:0] tppu;
    logic [23:0] cppu;
    logic [15:0] mult;
    logic [3:0][23:0] scr;   // nonnegative on-screen borders in manual mode
    logic [3:0][23:0] tb;    // nonnegative texture borders
  } job_t;

  typedef struct packed {
    logic [3:0][16:0] sf;
    logic [3:0][16:0] tf;
    logic             center;
  } res_t;

  // unsigned restoring divider widths
  localparam int DivW = 64;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_DIV,
    B_NEXT,
    B_DONE
  } bstate_t;

endpackage

`default_nettype wire

/* hdl/nine_slice_border_normalizer.sv */
// ----------------------------------------------------------------------------
// nine_slice_border_normalizer
// Turns sprite borders into screen and texture slice fractions.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   input    | in_valid/in_ready  | layout, texture, ppu and border fields
//   output   | out_valid/out_ready| screen_frac_*, tex_frac_*, draw_center
//   config   | cfg_we             | cfg_index, cfg_data
// An auto-mode word runs twelve 64-step divisions on one shared divider: one for each
// border scaling and one for each fraction. A manual word skips the scalings; a neutral
// word skips all divisions and goes straight to B_DONE. The front queues two words so
// input is taken while busy.
// Reset is synchronous; it restores the register defaults and empties the queue.
// A stalled output holds its word; the back end starts the next after it leaves.
`default_nettype none

module nine_slice_border_normalizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] layout_width,
  input  wire logic [23:0] layout_height,
  input  wire logic [15:0] texture_width,
  input  wire logic [15:0] texture_height,
  input  wire logic        texture_usable,
  input  wire logic [23:0] texture_ppu,
  input  wire logic [23:0] canvas_ppu,
  input  wire logic [23:0] border_left,
  input  wire logic [23:0] border_right,
  input  wire logic [23:0] border_bottom,
  input  wire logic [23:0] border_top,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [16:0]      screen_frac_left,
  output logic [16:0]      screen_frac_right,
  output logic [16:0]      screen_frac_bottom,
  output logic [16:0]      screen_frac_top,
  output logic [16:0]      tex_frac_left,
  output logic [16:0]      tex_frac_right,
  output logic [16:0]      tex_frac_bottom,
  output logic [16:0]      tex_frac_top,
  output logic             draw_center
);
  import nsb_pkg::*;

  logic job_valid, job_ready;
  job_t job;
  res_t res;

  nsb_front u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready,
    .layout_width, .layout_height, .texture_width, .texture_height,
    .texture_usable, .texture_ppu, .canvas_ppu,
    .border_left, .border_right, .border_bottom, .border_top,
    .job_valid, .job_ready, .job
  );

  nsb_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign screen_frac_left   = res.sf[0];
  assign screen_frac_right  = res.sf[1];
  assign screen_frac_bottom = res.sf[2];
  assign screen_frac_top    = res.sf[3];
  assign tex_frac_left      = res.tf[0];
  assign tex_frac_right     = res.tf[1];
  assign tex_frac_bottom    = res.tf[2];
  assign tex_frac_top       = res.tf[3];
  assign draw_center        = res.center;

endmodule

`default_nettype wire

/* hdl/nsb_front.sv */
// ----------------------------------------------------------------------------
// nsb_front
// Holds the configuration registers and classifies each input word.
// ----------------------------------------------------------------------------
`default_nettype none

module nsb_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [23:0]          cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [23:0]          layout_width,
  input  wire logic [23:0]          layout_height,
  input  wire logic [15:0]          texture_width,
  input  wire logic [15:0]          texture_height,
  input  wire logic                 texture_usable,
  input  wire logic [23:0]          texture_ppu,
  input  wire logic [23:0]          canvas_ppu,
  input  wire logic [23:0]          border_left,
  input  wire logic [23:0]          border_right,
  input  wire logic [23:0]          border_bottom,
  input  wire logic [23:0]          border_top,
  output logic                      job_valid,
  input  wire logic                 job_ready,
  output nsb_pkg::job_t             job
);
  import nsb_pkg::*;

  logic [1:0]       mode;
  logic             fill_en;
  logic [15:0]      mult;
  logic [3:0][23:0] sb;
  job_t             j;
  logic             ovr;
  logic [3:0][23:0] bin;

  // two-entry queue
  job_t q [2];
  logic [1:0] cnt;
  logic wp, rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_OFF;
      fill_en <= 1'b1;
      mult    <= 16'd256;
      sb      <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: mode    <= cfg_data[1:0];
        REG_FILL: fill_en <= cfg_data[0];
        REG_MULT: mult    <= cfg_data[15:0];
        REG_SB_L: sb[0]   <= cfg_data;
        REG_SB_R: sb[1]   <= cfg_data;
        REG_SB_B: sb[2]   <= cfg_data;
        REG_SB_T: sb[3]   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bin = {border_top, border_bottom, border_right, border_left};
    ovr = |{sb[0], sb[1], sb[2], sb[3]};
    j.neutral = !((mode == MODE_MANUAL) || (mode == MODE_AUTO)) ||
                layout_width[23] || (layout_width == '0) ||
                layout_height[23] || (layout_height == '0) ||
                !texture_usable || (texture_width == '0) || (texture_height == '0);
    j.auto_mode = (mode == MODE_AUTO);
    j.fill = fill_en;
    j.lw = layout_width;
    j.lh = layout_height;
    j.tw = texture_width;
    j.th = texture_height;
    j.tppu = texture_ppu;
    j.cppu = canvas_ppu;
    j.mult = (mult == '0) ? 16'd1 : mult;
    for (int i = 0; i < 4; i++) begin
      j.tb[i]  = bin[i][23] ? 24'd0 : bin[i];
      j.scr[i] = ovr ? (sb[i][23] ? 24'd0 : sb[i]) : j.tb[i];
    end
  end

  assign in_ready  = (cnt != 2'd2);
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q[wp] <= j;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (job_valid && job_ready) rp <= ~rp;
      cnt <= cnt + {1'b0, in_valid && in_ready} - {1'b0, job_valid && job_ready};
    end
  end

endmodule

`default_nettype wire

/* hdl/nsb_div.sv */
// ----------------------------------------------------------------------------
// nsb_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsb_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [nsb_pkg::DivW-1:0]   num,
  input  wire logic [nsb_pkg::DivW-1:0]   den,
  output logic                            done,
  output logic [nsb_pkg::DivW-1:0]        quo
);
  import nsb_pkg::*;

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] rem;
  logic [DivW-1:0] d;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DivW:0]   trial;

  assign trial = {rem, quo[DivW-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DivW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      d   <= den;
    end else if (busy) begin
      if (!trial[DivW]) rem <= trial[DivW-1:0];
      else              rem <= {rem[DivW-2:0], quo[DivW-1]};
      quo <= {quo[DivW-2:0], !trial[DivW]};
    end
  end

endmodule

`default_nettype wire

/* hdl/nsb_back.sv */
// ----------------------------------------------------------------------------
// nsb_back
// Works one job through the shared divider and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module nsb_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  output logic                 job_ready,
  input  wire nsb_pkg::job_t   job,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output nsb_pkg::res_t        res
);
  import nsb_pkg::*;

  bstate_t st, st_next;
  job_t    jb;
  logic [3:0] step;          // 0..3 auto, 4..7 screen, 8..11 texture
  logic [3:0][31:0] ui;
  logic [47:0] prod_a;       // b*cppu
  logic [39:0] prod_b;       // tppu*m
  logic        dstart, ddone;
  logic [DivW-1:0] dnum, dden, dquo;
  res_t acc;
  logic [32:0] sum;
  logic [32:0] lsize;
  logic [32:0] pden;
  logic [1:0]  k;

  assign k = step[1:0];

  nsb_div u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num(dnum), .den(dden), .done(ddone), .quo(dquo)
  );

  always_comb begin
    if (k[1]) begin
      sum   = {1'b0, ui[2]} + {1'b0, ui[3]};
      lsize = {9'd0, jb.lh};
    end else begin
      sum   = {1'b0, ui[0]} + {1'b0, ui[1]};
      lsize = {9'd0, jb.lw};
    end
    pden = (sum > lsize) ? sum : lsize;
  end

  always_comb begin
    st_next   = st;
    job_ready = 1'b0;
    dstart    = 1'b0;
    dnum      = '0;
    dden      = '1;
    case (step)
      4'd0, 4'd1, 4'd2, 4'd3: begin
        if (jb.tppu != '0) begin
          dnum = {8'd0, prod_a, 8'd0};
          dden = {24'd0, prod_b};
        end else begin
          dnum = {32'd0, jb.tb[k], 8'd0};
          dden = {48'd0, jb.mult};
        end
      end
      4'd4, 4'd5, 4'd6, 4'd7: begin
        dnum = {16'd0, ui[k], 16'd0};
        dden = {31'd0, pden};
      end
      default: begin
        dnum = {32'd0, jb.tb[k], 8'd0};
        dden = {48'd0, k[1] ? jb.th : jb.tw};
      end
    endcase
    unique case (st)
      B_IDLE: begin
        job_ready = !res_valid || res_ready;
        if (job_valid && job_ready) st_next = job.neutral ? B_DONE : B_MUL1;
      end
      B_MUL1: st_next = B_MUL2;
      B_MUL2: begin
        dstart  = 1'b1;
        st_next = B_DIV;
      end
      B_DIV:  if (ddone) st_next = B_NEXT;
      B_NEXT: st_next = (step == 4'd11) ? B_DONE :
                        ((step == 4'd3 || step >= 4'd4) ? B_MUL2 : B_MUL1);
      B_DONE: st_next = B_IDLE;
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (st == B_DONE) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: if (job_valid && job_ready) begin
        jb   <= job;
        step <= job.auto_mode ? 4'd0 : 4'd4;
        ui   <= {8'd0, job.scr[3], 8'd0, job.scr[2], 8'd0, job.scr[1], 8'd0, job.scr[0]};
        acc  <= '0;
      end
      B_MUL1: begin
        prod_a <= jb.tb[k] * jb.cppu;
        prod_b <= jb.tppu * jb.mult;
      end
      B_NEXT: begin
        if (step < 4'd4) begin
          ui[k] <= (dquo[63:32] != '0) ? 32'hFFFF_FFFF : dquo[31:0];
        end else if (step < 4'd8) begin
          acc.sf[k] <= dquo[16:0];
        end else begin
          acc.tf[k] <= (dquo > {47'd0, FracOne}) ? FracOne : dquo[16:0];
        end
        step <= step + 4'd1;
      end
      B_DONE: begin
        if (jb.neutral) begin
          res.sf     <= '0;
          res.tf     <= '0;
          res.center <= 1'b1;
        end else begin
          res.sf     <= acc.sf;
          res.tf     <= acc.tf;
          res.center <= jb.fill;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nine-slice border normalizer. Words are sent on
// the input channel. A model of the fraction arithmetic in the bench predicts
// each result, and every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import nsb_pkg::*;

  localparam int StallLimit = 30000;

  typedef struct packed {
    logic [23:0]      lw;
    logic [23:0]      lh;
    logic [15:0]      tw;
    logic [15:0]      th;
    logic             usable;
    logic [23:0]      tppu;
    logic [23:0]      cppu;
    logic [3:0][23:0] bd;
  } sprite_t;

  typedef struct packed {
    logic [3:0][16:0] sf;
    logic [3:0][16:0] tf;
    logic             center;
  } slices_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  sprite_t cur = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0][16:0] sf_o, tf_o;
  logic draw_center;

  // register copies used by the predictor
  mode_t            mode_q = MODE_OFF;
  logic             fill_q = 1'b1;
  logic [15:0]      mult_q = 16'd256;
  logic [3:0][23:0] sb_q = '0;

  slices_t expected_slices[$];
  int errors = 0;
  bit calm = 1'b0;       // no idling on either side
  int hold_req = 0;      // receiver hold-off request, counted in the ready process
  int hold_cnt = 0;
  int idle_cnt = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nine_slice_border_normalizer u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .layout_width(cur.lw), .layout_height(cur.lh),
    .texture_width(cur.tw), .texture_height(cur.th),
    .texture_usable(cur.usable), .texture_ppu(cur.tppu), .canvas_ppu(cur.cppu),
    .border_left(cur.bd[0]), .border_right(cur.bd[1]),
    .border_bottom(cur.bd[2]), .border_top(cur.bd[3]),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_frac_left(sf_o[0]), .screen_frac_right(sf_o[1]),
    .screen_frac_bottom(sf_o[2]), .screen_frac_top(sf_o[3]),
    .tex_frac_left(tf_o[0]), .tex_frac_right(tf_o[1]),
    .tex_frac_bottom(tf_o[2]), .tex_frac_top(tf_o[3]),
    .draw_center(draw_center)
  );

  function automatic longint unsigned clip_neg(logic [23:0] v);
    longint signed s;
    s = longint'($signed(v));
    return s > 0 ? longint'(s) : 0;
  endfunction

  function automatic slices_t predict_slices(sprite_t w);
    slices_t r;
    longint signed lwv, lhv;
    longint unsigned ui[4];
    longint unsigned m, b, q, sum, den, sz;
    bit ovr;
    r = '0;
    r.center = 1'b1;
    lwv = longint'($signed(w.lw));
    lhv = longint'($signed(w.lh));
    if (mode_q != MODE_MANUAL && mode_q != MODE_AUTO) return r;
    if (lwv <= 0 || lhv <= 0 || !w.usable || w.tw == 0 || w.th == 0) return r;
    if (mode_q == MODE_AUTO) begin
      m = (mult_q == 0) ? 1 : mult_q;
      for (int i = 0; i < 4; i++) begin
        b = clip_neg(w.bd[i]);
        if (w.tppu != 0) q = (b * w.cppu * 256) / (longint'(w.tppu) * m);
        else q = (b * 256) / m;
        ui[i] = (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
      end
    end else begin
      ovr = |sb_q;
      for (int i = 0; i < 4; i++) ui[i] = clip_neg(ovr ? sb_q[i] : w.bd[i]);
    end
    for (int p = 0; p < 2; p++) begin
      sz = (p == 0) ? longint'(lwv) : longint'(lhv);
      sum = ui[2*p] + ui[2*p+1];
      den = (sum > sz) ? sum : sz;
      r.sf[2*p] = 17'((ui[2*p] * 65536) / den);
      r.sf[2*p+1] = 17'((ui[2*p+1] * 65536) / den);
    end
    for (int i = 0; i < 4; i++) begin
      sz = (i < 2) ? w.tw : w.th;
      q = (clip_neg(w.bd[i]) * 256) / sz;
      r.tf[i] = (q > 65536) ? FracOne : 17'(q);
    end
    r.center = fill_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    slices_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_slices.size() == 0) begin
        report_mismatch("unexpected word", 0, 0);
      end else begin
        e = expected_slices.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (sf_o[i] !== e.sf[i]) report_mismatch($sformatf("screen_frac[%0d]", i),
                                                   sf_o[i], e.sf[i]);
          if (tf_o[i] !== e.tf[i]) report_mismatch($sformatf("tex_frac[%0d]", i),
                                                   tf_o[i], e.tf[i]);
        end
        if (draw_center !== e.center) report_mismatch("draw_center", draw_center, e.center);
      end
    end
  end

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(sprite_t w);
    int gap;
    if (!calm && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cur <= w;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    expected_slices.push_back(predict_slices(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_slices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [23:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: mode_q = mode_t'(d[1:0]);
      REG_FILL: fill_q = d[0];
      REG_MULT: mult_q = d[15:0];
      REG_SB_L, REG_SB_R, REG_SB_B, REG_SB_T:
        sb_q[2'(int'(idx) - int'(REG_SB_L))] = d;
      default: ;
    endcase
  endtask

  task automatic set_screen_borders(logic [23:0] l, logic [23:0] r, logic [23:0] b,
                                    logic [23:0] t);
    cfg_write(REG_SB_L, l);
    cfg_write(REG_SB_R, r);
    cfg_write(REG_SB_B, b);
    cfg_write(REG_SB_T, t);
  endtask

  function automatic sprite_t plain_sprite();
    sprite_t w;
    w.lw = 24'd100 << 8;
    w.lh = 24'd50 << 8;
    w.tw = 16'd64;
    w.th = 16'd32;
    w.usable = 1'b1;
    w.tppu = 24'd100 << 8;
    w.cppu = 24'd100 << 8;
    w.bd = {24'd4 << 8, 24'd4 << 8, 24'd8 << 8, 24'd8 << 8};
    return w;
  endfunction

  function automatic logic [23:0] rand_border(int unsigned span);
    logic [23:0] v;
    case ($urandom_range(9))
      0: v = -24'($urandom_range(1, span));
      1: v = 24'($urandom);
      default: v = 24'($urandom_range(0, span));
    endcase
    return v;
  endfunction

  function automatic sprite_t rand_sprite(bit shaped);
    sprite_t w;
    int unsigned span;
    if (!shaped) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           1'($urandom)};
      return w;
    end
    case ($urandom_range(3))
      0: span = 24'h7FFFFF;
      1: span = 1 << 20;
      default: span = 1 << 14;
    endcase
    w.lw = 24'($urandom_range(1, span));
    w.lh = 24'($urandom_range(1, span));
    w.tw = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                    : 16'($urandom_range(1, 512));
    w.th = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                    : 16'($urandom_range(1, 512));
    w.usable = 1'b1;
    w.tppu = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom);
    case ($urandom_range(9))
      0: w.cppu = 24'd0;
      1, 2: w.cppu = 24'd100 << 8;
      default: w.cppu = 24'($urandom);
    endcase
    for (int i = 0; i < 4; i++) w.bd[i] = rand_border(span);
    return w;
  endfunction

  task automatic test_neutral();
    sprite_t w;
    w = plain_sprite();
    send_word(w);                    // reset mode is off
    drain();
    cfg_write(REG_MODE, 24'(MODE_RSVD));
    send_word(w);
    drain();
    cfg_write(REG_MODE, 24'(MODE_MANUAL));
    w.lw = 24'd0;           send_word(w);
    w.lw = 24'h800000;      send_word(w);
    w = plain_sprite(); w.lh = 24'd0;   send_word(w);
    w = plain_sprite(); w.usable = 1'b0; send_word(w);
    w = plain_sprite(); w.tw = 16'd0;   send_word(w);
    w = plain_sprite(); w.th = 16'd0;   send_word(w);
    drain();
  endtask

  task automatic test_manual();
    sprite_t w;
    cfg_write(REG_NONE, 24'hFFFFFF);          // unmapped index is ignored
    cfg_write(REG_FILL, 24'd0);
    w = plain_sprite();
    send_word(w);
    // overlapping borders shrink in proportion
    w.bd = {24'd10 << 8, 24'd10 << 8, 24'd90 << 8, 24'd30 << 8};
    send_word(w);
    // negative borders and texture fraction clamp
    w.bd = {24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'd1};
    send_word(w);
    w.lw = 24'h7FFFFF; w.lh = 24'd1; w.tw = 16'hFFFF; w.th = 16'd1;
    send_word(w);
    drain();
    cfg_write(REG_FILL, 24'd1);
    set_screen_borders(24'd20 << 8, 24'hFFF000, 24'd0, 24'h7FFFFF);
    w = plain_sprite();
    send_word(w);
    w.lw = 24'd1;
    send_word(w);
    drain();
    set_screen_borders(24'h800000, 24'd0, 24'd1, 24'd0);
    send_word(plain_sprite());
    drain();
    set_screen_borders(24'd0, 24'd0, 24'd0, 24'd0);
  endtask

  task automatic test_auto();
    sprite_t w;
    cfg_write(REG_MODE, 24'(MODE_AUTO));
    w = plain_sprite();
    send_word(w);
    w.tppu = 24'd0;        send_word(w);         // unknown texture ppu
    w = plain_sprite(); w.cppu = 24'd0; send_word(w);   // zero canvas ppu
    // saturation of the wide border
    w = plain_sprite();
    w.tppu = 24'd1; w.cppu = 24'hFFFFFF;
    w.bd = {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000};
    send_word(w);
    drain();
    cfg_write(REG_MULT, 24'd0);                  // floored to one lsb
    send_word(plain_sprite());
    w.tppu = 24'hFFFFFF; send_word(w);
    drain();
    cfg_write(REG_MULT, 24'hFFFF);
    send_word(plain_sprite());
    drain();
    cfg_write(REG_MULT, 24'd256);
  endtask

  task automatic test_backpressure();
    calm = 1'b1;
    hold_req = 3000;
    for (int i = 0; i < 6; i++) send_word(rand_sprite(1'b1));
    drain();
    calm = 1'b0;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: cfg_write(REG_MODE, 24'(MODE_AUTO));
        1: cfg_write(REG_MODE, 24'(MODE_MANUAL));
        2: set_screen_borders(24'($urandom), 24'($urandom), 24'($urandom_range(0, 4096)),
                              24'($urandom_range(0, 4096)));
        3: cfg_write(REG_MODE, 24'(MODE_OFF));
        4: begin
          cfg_write(REG_MODE, 24'(MODE_AUTO));
          cfg_write(REG_MULT, 24'($urandom_range(0, 65535)));
          cfg_write(REG_FILL, 24'd0);
        end
        5: cfg_write(REG_MODE, 24'(MODE_RSVD));
        default: begin
          cfg_write(REG_MODE, 24'(MODE_MANUAL));
          set_screen_borders(24'd0, 24'd0, 24'd0, 24'd0);
          cfg_write(REG_FILL, 24'd1);
        end
      endcase
      calm = (ph == 1);
      for (int n = 0; n < 120; n++) send_word(rand_sprite($urandom_range(9) != 0));
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_neutral();
    test_manual();
    test_auto();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
hdl/nsb_pkg.sv
hdl/nsb_front.sv
hdl/nsb_div.sv
hdl/nsb_back.sv
hdl/nine_slice_border_normalizer.sv
tb/tb_top.sv
